/* design/ssmt_pkg.sv */
package ssmt_pkg;

   // Hodoscope geometry in 1/16 mm units
   localparam int PITCH_UNITS  = 224;
   localparam int OFFSET_UNITS = 160;

   // u / 224 is taken as (u >> 5) / 7, the /7 as a multiply by 293 and a shift by 11.
   // This is exact for a quotient operand below 448.
   localparam int PITCH_SHIFT  = 5;
   localparam int RECIP_SEVEN  = 293;
   localparam int RECIP_SHIFT  = 11;

   localparam int ENERGY_WIDTH = 16;
   localparam int POS_WIDTH    = 16;
   localparam int TILE_WIDTH   = 6;
   localparam int MASK_WIDTH   = 15;
   localparam int SEGCNT_WIDTH = 4;
   localparam int MULT_WIDTH   = 6;
   localparam int COUNT_WIDTH  = 7;

   localparam int THR_WIDTH    = 20;
   localparam int WIN_WIDTH    = 4;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 20;

   localparam logic [THR_WIDTH-1:0]  BEAM_THR_RESET = 20'd100;
   localparam logic [THR_WIDTH-1:0]  TOF_THR_RESET  = 20'd200;
   localparam logic [WIN_WIDTH-1:0]  WIN_LOW_RESET  = 4'd4;
   localparam logic [WIN_WIDTH-1:0]  WIN_HIGH_RESET = 4'd10;
   localparam logic [MULT_WIDTH-1:0] MIN_MULT_RESET = 6'd2;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_BEAM_THRESHOLD   = 3'd0,
      CSR_TOF_THRESHOLD    = 3'd1,
      CSR_WINDOW_LOW       = 3'd2,
      CSR_WINDOW_HIGH      = 3'd3,
      CSR_MIN_MULTIPLICITY = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic step;
      logic clear;
   } scan_ctl_type;

endpackage

/* design/ssmt_seg_map.sv */
module ssmt_seg_map #(
   parameter int SEGMENT_COUNT = 15,
   parameter int TILE_COUNT    = 34,
   parameter int AW            = 6
) (
   input  logic                                  func,
   input  logic                                  hit_valid,
   input  logic signed [ssmt_pkg::POS_WIDTH-1:0] position_x,
   input  logic [ssmt_pkg::TILE_WIDTH-1:0]       tile_number,
   output logic [AW-1:0]                         addr,
   output logic                                  hit_ok
);

   localparam int SPAN = SEGMENT_COUNT * ssmt_pkg::PITCH_UNITS;
   localparam int BIAS = ssmt_pkg::OFFSET_UNITS + SEGMENT_COUNT * (ssmt_pkg::PITCH_UNITS / 2);

   logic signed [17:0] u;
   logic               in_span;
   logic [8:0]         v;
   logic [17:0]        prod;
   logic [6:0]         seg;
   logic               tile_ok;

   always_comb begin
      u       = 18'(position_x) + 18'(BIAS);
      in_span = !u[17] && (u[16:0] < 17'(SPAN));
      v       = u[13:5];
      prod    = 18'(v) * 18'(ssmt_pkg::RECIP_SEVEN);
      seg     = prod[17:ssmt_pkg::RECIP_SHIFT];
      tile_ok = ({1'b0, tile_number} < 7'(TILE_COUNT));
      if (func) begin
         addr   = AW'(SEGMENT_COUNT) + AW'(tile_number);
         hit_ok = hit_valid && tile_ok;
      end else begin
         addr   = AW'(seg);
         hit_ok = hit_valid && in_span;
      end
   end

endmodule

/* design/ssmt_sum_mem.sv */
module ssmt_sum_mem #(
   parameter int DEPTH = 49,
   parameter int AW    = 6,
   parameter int SW    = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [SW-1:0] wr_data,
   input  logic          clear_hits,
   output logic [SW-1:0] rd_sum,
   output logic          rd_hit
);

   logic [SW-1:0]    mem [DEPTH];
   logic [SW-1:0]    rd_data_ff;
   logic [AW-1:0]    rd_addr_ff;
   logic [DEPTH-1:0] hit_ff;
   logic [DEPTH-1:0] hit_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // a cleared entry reads as zero without touching the array
   always_comb begin
      hit_in = hit_ff;
      if (clear_hits) begin
         hit_in = '0;
      end else if (wr_en) begin
         hit_in = hit_ff | (DEPTH'(1) << wr_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign rd_hit = hit_ff[rd_addr_ff];
   assign rd_sum = rd_hit ? rd_data_ff : '0;

endmodule

/* design/ssmt_scan.sv */
module ssmt_scan #(
   parameter int SEGMENT_COUNT = 15,
   parameter int AW            = 6,
   parameter int SW            = 20
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  ssmt_pkg::scan_ctl_type                   ctl,
   input  logic [AW-1:0]                            entry,
   input  logic [SW-1:0]                            sum,
   input  logic                                     hit,
   input  logic [ssmt_pkg::THR_WIDTH-1:0]           beam_thr,
   input  logic [ssmt_pkg::THR_WIDTH-1:0]           tof_thr,
   input  logic [ssmt_pkg::WIN_WIDTH-1:0]           win_low,
   input  logic [ssmt_pkg::WIN_WIDTH-1:0]           win_high,
   output logic [ssmt_pkg::MASK_WIDTH-1:0]          mask,
   output logic [ssmt_pkg::COUNT_WIDTH-1:0]         seg_cnt,
   output logic [ssmt_pkg::COUNT_WIDTH-1:0]         tile_cnt,
   output logic                                     in_window
);

   localparam int CW = (SW > ssmt_pkg::THR_WIDTH) ? SW : ssmt_pkg::THR_WIDTH;

   logic [ssmt_pkg::MASK_WIDTH-1:0]  mask_ff, mask_in;
   logic [ssmt_pkg::COUNT_WIDTH-1:0] seg_cnt_ff, seg_cnt_in;
   logic [ssmt_pkg::COUNT_WIDTH-1:0] tile_cnt_ff, tile_cnt_in;
   logic                             win_ff, win_in;
   logic [6:0]                       idx;
   logic                             is_seg;
   logic                             seg_ok;
   logic                             tile_ok;

   always_comb begin
      idx     = 7'(entry);
      is_seg  = ({1'b0, entry} < (AW+1)'(SEGMENT_COUNT));
      seg_ok  = hit && is_seg && (CW'(sum) >= CW'(beam_thr));
      tile_ok = hit && !is_seg && (CW'(sum) >= CW'(tof_thr));

      mask_in     = mask_ff;
      seg_cnt_in  = seg_cnt_ff;
      tile_cnt_in = tile_cnt_ff;
      win_in      = win_ff;
      if (ctl.clear) begin
         mask_in     = '0;
         seg_cnt_in  = '0;
         tile_cnt_in = '0;
         win_in      = 1'b0;
      end else if (ctl.step) begin
         if (seg_ok) begin
            seg_cnt_in = seg_cnt_ff + 1'b1;
            if (idx < 7'(ssmt_pkg::MASK_WIDTH)) begin
               mask_in = mask_ff | (ssmt_pkg::MASK_WIDTH'(1) << idx[3:0]);
            end
            if (idx >= 7'(win_low) && idx <= 7'(win_high)) begin
               win_in = 1'b1;
            end
         end
         if (tile_ok) begin
            tile_cnt_in = tile_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= '0;
         seg_cnt_ff  <= '0;
         tile_cnt_ff <= '0;
         win_ff      <= 1'b0;
      end else begin
         mask_ff     <= mask_in;
         seg_cnt_ff  <= seg_cnt_in;
         tile_cnt_ff <= tile_cnt_in;
         win_ff      <= win_in;
      end
   end

   assign mask      = mask_ff;
   assign seg_cnt   = seg_cnt_ff;
   assign tile_cnt  = tile_cnt_ff;
   assign in_window = win_ff;

endmodule

/* design/segment_sum_multiplicity_trigger_unit.sv */
// Segment-sum multiplicity trigger.
// Requests arrive on the req_ channel (valid/ready), one hit per request; the
// request with req_last_in_event set closes the event. Hodoscope hits are
// mapped to a segment from their x position, tile hits address a tile; the
// energy is added, saturating, into a per-entry sum kept in one synchronous
// memory of SEGMENT_COUNT + TILE_COUNT entries with a hit flag per entry.
// Each request is a memory read, then the add and write-back; a new request
// is taken only once that write-back is done. After a closing request the
// block scans the memory one entry a cycle, then drains the last read into
// the counters and loads the result into an output register on rsp_, where
// it holds until rsp_ready. Further requests are taken while a result
// waits; only the end of the next scan stalls until the register is free.
// Clearing the sums is done by dropping the hit flags, with no memory pass.
// csr_we writes a threshold or window register at once; write it only while
// idle. Synchronous reset restores register defaults and empties all sums.
module segment_sum_multiplicity_trigger_unit #(
   parameter int SEGMENT_COUNT = 15,
   parameter int TILE_COUNT    = 34,
   parameter int SUM_WIDTH     = 20
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic                                       req_func,
   input  logic                                       req_hit_valid,
   input  logic signed [ssmt_pkg::POS_WIDTH-1:0]      req_position_x,
   input  logic [ssmt_pkg::TILE_WIDTH-1:0]            req_tile_number,
   input  logic [ssmt_pkg::ENERGY_WIDTH-1:0]          req_energy_kev,
   input  logic                                       req_last_in_event,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic                                       rsp_trigger,
   output logic                                       rsp_in_window,
   output logic [ssmt_pkg::MASK_WIDTH-1:0]            rsp_segment_mask,
   output logic [ssmt_pkg::SEGCNT_WIDTH-1:0]          rsp_segment_count,
   output logic [ssmt_pkg::MULT_WIDTH-1:0]            rsp_tile_multiplicity,
   input  logic                                       csr_we,
   input  logic [ssmt_pkg::CSR_ADDR_WIDTH-1:0]        csr_addr,
   input  logic [ssmt_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata
);

   localparam int DEPTH = SEGMENT_COUNT + TILE_COUNT;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = SUM_WIDTH;

   ssmt_pkg::state_type state_ff, state_in;

   logic [ssmt_pkg::THR_WIDTH-1:0]  beam_thr_ff, tof_thr_ff;
   logic [ssmt_pkg::WIN_WIDTH-1:0]  win_low_ff, win_high_ff;
   logic [ssmt_pkg::MULT_WIDTH-1:0] min_mult_ff;

   logic [AW-1:0]                     map_addr;
   logic                              map_ok;
   logic [AW-1:0]                     addr_ff;
   logic                              hit_ok_ff;
   logic                              last_ff;
   logic [ssmt_pkg::ENERGY_WIDTH-1:0] energy_ff;

   logic [AW-1:0]  scan_idx_ff, scan_idx_in;
   logic [AW-1:0]  scan_entry_ff;
   logic           step_ff, step_in;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [SW-1:0]  wr_data;
   logic [SW:0]    sum_wide;
   logic [SW-1:0]  rd_sum;
   logic           rd_hit;
   logic           load_rsp;
   logic           accept;

   ssmt_pkg::scan_ctl_type scan_ctl;
   logic [ssmt_pkg::MASK_WIDTH-1:0]  scan_mask;
   logic [ssmt_pkg::COUNT_WIDTH-1:0] scan_seg_cnt;
   logic [ssmt_pkg::COUNT_WIDTH-1:0] scan_tile_cnt;
   logic                             scan_win;

   logic                                 rsp_valid_ff;
   logic                                 rsp_trigger_ff;
   logic                                 rsp_in_window_ff;
   logic [ssmt_pkg::MASK_WIDTH-1:0]      rsp_mask_ff;
   logic [ssmt_pkg::SEGCNT_WIDTH-1:0]    rsp_seg_cnt_ff;
   logic [ssmt_pkg::MULT_WIDTH-1:0]      rsp_mult_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         beam_thr_ff <= ssmt_pkg::BEAM_THR_RESET;
         tof_thr_ff  <= ssmt_pkg::TOF_THR_RESET;
         win_low_ff  <= ssmt_pkg::WIN_LOW_RESET;
         win_high_ff <= ssmt_pkg::WIN_HIGH_RESET;
         min_mult_ff <= ssmt_pkg::MIN_MULT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            ssmt_pkg::CSR_BEAM_THRESHOLD:   beam_thr_ff <= csr_wdata;
            ssmt_pkg::CSR_TOF_THRESHOLD:    tof_thr_ff  <= csr_wdata;
            ssmt_pkg::CSR_WINDOW_LOW:       win_low_ff  <= csr_wdata[ssmt_pkg::WIN_WIDTH-1:0];
            ssmt_pkg::CSR_WINDOW_HIGH:      win_high_ff <= csr_wdata[ssmt_pkg::WIN_WIDTH-1:0];
            ssmt_pkg::CSR_MIN_MULTIPLICITY: min_mult_ff <= csr_wdata[ssmt_pkg::MULT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   ssmt_seg_map #(
      .SEGMENT_COUNT (SEGMENT_COUNT),
      .TILE_COUNT    (TILE_COUNT),
      .AW            (AW)
   ) u_map (
      .func        (req_func),
      .hit_valid   (req_hit_valid),
      .position_x  (req_position_x),
      .tile_number (req_tile_number),
      .addr        (map_addr),
      .hit_ok      (map_ok)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssmt_pkg::ST_IDLE: begin
            if (req_valid) state_in = ssmt_pkg::ST_ACC;
         end
         ssmt_pkg::ST_ACC: begin
            state_in = last_ff ? ssmt_pkg::ST_SCAN : ssmt_pkg::ST_IDLE;
         end
         ssmt_pkg::ST_SCAN: begin
            if (scan_idx_ff == AW'(DEPTH - 1)) state_in = ssmt_pkg::ST_DRAIN;
         end
         ssmt_pkg::ST_DRAIN: begin
            state_in = ssmt_pkg::ST_DONE;
         end
         ssmt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ssmt_pkg::ST_IDLE;
         end
         default: state_in = ssmt_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready      = (state_ff == ssmt_pkg::ST_IDLE);
      wr_en          = (state_ff == ssmt_pkg::ST_ACC) && hit_ok_ff;
      rd_addr        = (state_ff == ssmt_pkg::ST_SCAN) ? scan_idx_ff : map_addr;
      load_rsp       = (state_ff == ssmt_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      step_in        = (state_ff == ssmt_pkg::ST_SCAN);
      scan_ctl.step  = step_ff;
      scan_ctl.clear = load_rsp;
      scan_idx_in    = '0;
      if (state_ff == ssmt_pkg::ST_SCAN) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ssmt_pkg::ST_IDLE;
         scan_idx_ff <= '0;
         step_ff     <= 1'b0;
         hit_ok_ff   <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         step_ff     <= step_in;
         if (accept) begin
            hit_ok_ff <= map_ok;
            last_ff   <= req_last_in_event;
         end
      end
   end

   // scan_entry_ff names the entry whose read data is out of the memory
   always_ff @(posedge clock) begin
      scan_entry_ff <= scan_idx_ff;
      if (accept) begin
         addr_ff   <= map_addr;
         energy_ff <= req_energy_kev;
      end
   end

   // saturating accumulate
   always_comb begin
      sum_wide = {1'b0, rd_sum} + (SW+1)'(energy_ff);
      wr_data  = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
   end

   ssmt_sum_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .SW    (SW)
   ) u_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (rd_addr),
      .wr_en      (wr_en),
      .wr_addr    (addr_ff),
      .wr_data    (wr_data),
      .clear_hits (load_rsp),
      .rd_sum     (rd_sum),
      .rd_hit     (rd_hit)
   );

   ssmt_scan #(
      .SEGMENT_COUNT (SEGMENT_COUNT),
      .AW            (AW),
      .SW            (SW)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .entry     (scan_entry_ff),
      .sum       (rd_sum),
      .hit       (rd_hit),
      .beam_thr  (beam_thr_ff),
      .tof_thr   (tof_thr_ff),
      .win_low   (win_low_ff),
      .win_high  (win_high_ff),
      .mask      (scan_mask),
      .seg_cnt   (scan_seg_cnt),
      .tile_cnt  (scan_tile_cnt),
      .in_window (scan_win)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_trigger_ff   <= scan_win &&
                             (scan_tile_cnt >= ssmt_pkg::COUNT_WIDTH'(min_mult_ff));
         rsp_in_window_ff <= scan_win;
         rsp_mask_ff      <= scan_mask;
         rsp_seg_cnt_ff   <= scan_seg_cnt[ssmt_pkg::SEGCNT_WIDTH-1:0];
         rsp_mult_ff      <= scan_tile_cnt[ssmt_pkg::MULT_WIDTH-1:0];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trigger           = rsp_trigger_ff;
   assign rsp_in_window         = rsp_in_window_ff;
   assign rsp_segment_mask      = rsp_mask_ff;
   assign rsp_segment_count     = rsp_seg_cnt_ff;
   assign rsp_tile_multiplicity = rsp_mult_ff;

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ssmt_pkg::ST_DONE))
      else $error("result raised outside the done state");

   a_last_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssmt_pkg::ST_ACC && last_ff) |=> (state_ff == ssmt_pkg::ST_SCAN))
      else $error("closing request did not start the scan");

   a_trigger_needs_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_trigger_ff || rsp_in_window_ff))
      else $error("trigger set without an in-window segment");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssmt_pkg::ST_SCAN) |-> (scan_idx_ff <= AW'(DEPTH - 1)))
      else $error("scan index beyond the memory");
`endif

endmodule
